// ===== design/rlpf_pkg.sv =====
// ----------------------------------------------------------------------------
// rlpf_pkg
// Shared widths, constants and register indices of the resonant low-pass filter.
// ----------------------------------------------------------------------------
package rlpf_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 9;
  localparam int VEL_W     = 18;
  localparam int SAMP_W    = 13;
  localparam int CFG_IDX_W = 3;

  localparam int VEL_MAX    = 131071;
  localparam int VEL_MIN    = -131072;
  localparam int OUT_OFFSET = 32'h8000;
  localparam int OUT_MAX    = 65535;

  localparam logic signed [SAMP_W-1:0] SAMP_CENTRE = 13'sh800;

  localparam logic [COEF_W-1:0] CUT_RESET = 9'd64;
  localparam logic [COEF_W-1:0] RES_RESET = 9'd253;
  localparam logic [COEF_W-1:0] MIX_RESET = 9'd0;

  localparam logic [CFG_IDX_W-1:0] REG_CUT_CH0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUT_CH1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RES_CH0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RES_CH1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_CH0 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_CH1 = 3'd5;

endpackage

// ===== design/resonant_lowpass_filter_unit.sv =====
// an accepted transaction steps through S_MUL_MIX, S_MUL_RES and S_MUL_CUT to S_OUT, with
// MP_W = max(FRAC_BITS+2, 10) as the multiplier operand width in bits
// a new transaction is taken only in S_IDLE, once the last result has entered the output
// register; the one bit-serial shift-add multiplier forms the three products one after another
// reset: coefficients return to their defaults, height and velocity of every channel to zero
// ----------------------------------------------------------------------------
// resonant_lowpass_filter_unit
// Multi-channel resonant two-pole low-pass filter, mass-spring model, Q fixed point.
// ----------------------------------------------------------------------------
module resonant_lowpass_filter_unit
  import rlpf_pkg::*;
#(
  parameter int FRAC_BITS  = 8,
  parameter int CLIP_LIMIT = 2048,
  parameter int CHANNELS   = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COEF_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 channel_i,
  input  logic [SAMPLE_W-1:0]  sample_in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [SAMPLE_W-1:0]  sample_out_o
);

  localparam int FIX_ONE  = 1 << FRAC_BITS;
  localparam int MP_W     = (FRAC_BITS + 2 > 10) ? FRAC_BITS + 2 : 10;
  localparam int HEIGHT_W = $clog2(CLIP_LIMIT) + 2;
  localparam int LPIN_W   = SAMP_W + MP_W - FRAC_BITS;
  localparam int DIFF_W   = ((LPIN_W > HEIGHT_W) ? LPIN_W : HEIGHT_W) + 1;
  localparam int MC_W     = (DIFF_W > VEL_W) ? DIFF_W : VEL_W;
  localparam int ACC_W    = MC_W + MP_W;
  localparam int PS_W     = ACC_W - FRAC_BITS;
  localparam int VS_W     = PS_W + 1;
  localparam int H_W      = ((HEIGHT_W > VEL_W) ? HEIGHT_W : VEL_W) + 1;
  localparam int OP_W     = H_W + 4;
  localparam int CNT_W    = $clog2(MP_W);
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic signed [VS_W-1:0]     VS_MAX   = VS_W'(VEL_MAX);
  localparam logic signed [VS_W-1:0]     VS_MIN   = VS_W'(VEL_MIN);
  localparam logic signed [H_W-1:0]      H_CLIP_P = H_W'(CLIP_LIMIT);
  localparam logic signed [H_W-1:0]      H_CLIP_N = H_W'(-CLIP_LIMIT);
  localparam logic signed [OP_W-1:0]     OP_OFFS  = OP_W'(OUT_OFFSET);
  localparam logic signed [OP_W-1:0]     OP_MAX   = OP_W'(OUT_MAX);
  localparam logic signed [HEIGHT_W-1:0] HT_CLIP  = HEIGHT_W'(CLIP_LIMIT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_MIX,
    S_MUL_RES,
    S_MUL_CUT,
    S_OUT
  } state_e;

  // control state
  state_e                     state_q, state_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       out_valid_q, out_valid_d;
  logic [COEF_W-1:0]          cut_q [2];
  logic [COEF_W-1:0]          res_q [2];
  logic [COEF_W-1:0]          mix_q [2];
  logic signed [HEIGHT_W-1:0] height_q [CHANNELS];
  logic signed [VEL_W-1:0]    vel_q [CHANNELS];

  // datapath
  logic                       cb_q, cb_d;
  logic [CH_IDX_W-1:0]        ch_q, ch_d;
  logic signed [ACC_W-1:0]    mc_q, mc_d;
  logic [MP_W-1:0]            mp_q, mp_d;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic signed [LPIN_W-1:0]   lpin_q, lpin_d;
  logic signed [PS_W-1:0]     fm2_q, fm2_d;
  logic [SAMPLE_W-1:0]        result_q, result_d;
  logic [SAMPLE_W-1:0]        out_q, out_d;

  logic                       in_fire, mul_last, out_free, commit;
  logic signed [SAMP_W-1:0]   samp;
  logic signed [ACC_W-1:0]    addend, acc_step;
  logic signed [PS_W-1:0]     prod_shr;
  logic signed [HEIGHT_W-1:0] h_cur;
  logic signed [VEL_W-1:0]    v_cur;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [VS_W-1:0]     vel_sum;
  logic signed [VEL_W-1:0]    vel_sat;
  logic signed [H_W-1:0]      h_sum;
  logic signed [HEIGHT_W-1:0] h_clip;
  logic signed [OP_W-1:0]     out_pre;
  logic [SAMPLE_W-1:0]        out_sat;

  assign in_ready_o   = (state_q == S_IDLE);
  assign in_fire      = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;
  assign out_free     = !out_valid_q || out_ready_i;
  assign mul_last     = (cnt_q == CNT_W'(MP_W - 1));
  assign commit       = (state_q == S_MUL_CUT) && mul_last;

  assign samp  = $signed({1'b0, sample_in_i[SAMPLE_W-1:4]}) - SAMP_CENTRE;
  assign h_cur = height_q[ch_q];
  assign v_cur = vel_q[ch_q];

  // one shift-add step; the top multiplier bit carries negative weight
  assign addend   = mp_q[0] ? (mul_last ? -mc_q : mc_q) : '0;
  assign acc_step = acc_q + addend;
  assign prod_shr = PS_W'(acc_step >>> FRAC_BITS);

  assign diff = DIFF_W'(lpin_q) - DIFF_W'(h_cur);

  always_comb begin
    vel_sum = VS_W'(fm2_q) + VS_W'(prod_shr);
    if (vel_sum > VS_MAX) begin
      vel_sat = VEL_W'(VS_MAX);
    end else if (vel_sum < VS_MIN) begin
      vel_sat = VEL_W'(VS_MIN);
    end else begin
      vel_sat = VEL_W'(vel_sum);
    end
    h_sum   = H_W'(h_cur) + H_W'(vel_sat);
    out_pre = (OP_W'(h_sum) <<< 3) + OP_OFFS;
    if (out_pre < 0) begin
      out_sat = '0;
    end else if (out_pre > OP_MAX) begin
      out_sat = '1;
    end else begin
      out_sat = out_pre[SAMPLE_W-1:0];
    end
    if (h_sum > H_CLIP_P) begin
      h_clip = HT_CLIP;
    end else if (h_sum < H_CLIP_N) begin
      h_clip = -HT_CLIP;
    end else begin
      h_clip = HEIGHT_W'(h_sum);
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cb_d        = cb_q;
    ch_d        = ch_q;
    mc_d        = mc_q;
    mp_d        = mp_q;
    acc_d       = acc_q;
    lpin_d      = lpin_q;
    fm2_d       = fm2_q;
    result_d    = result_q;
    out_d       = out_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cb_d    = channel_i;
          ch_d    = (CHANNELS > 1) ? CH_IDX_W'(channel_i) : '0;
          mc_d    = ACC_W'(samp);
          mp_d    = MP_W'(FIX_ONE) - MP_W'(mix_q[channel_i]);
          acc_d   = '0;
          cnt_d   = '0;
          state_d = S_MUL_MIX;
        end
      end
      S_MUL_MIX, S_MUL_RES, S_MUL_CUT: begin
        acc_d = acc_step;
        mc_d  = mc_q <<< 1;
        mp_d  = mp_q >> 1;
        cnt_d = cnt_q + 1'b1;
        if (mul_last) begin
          acc_d = '0;
          cnt_d = '0;
          case (state_q)
            S_MUL_MIX: begin
              lpin_d  = LPIN_W'(prod_shr);
              mc_d    = ACC_W'(v_cur);
              mp_d    = MP_W'(res_q[cb_q]);
              state_d = S_MUL_RES;
            end
            S_MUL_RES: begin
              fm2_d   = prod_shr;
              mc_d    = ACC_W'(diff);
              mp_d    = MP_W'(cut_q[cb_q]);
              state_d = S_MUL_CUT;
            end
            default: begin
              result_d = out_sat;
              state_d  = S_OUT;
            end
          endcase
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_d       = result_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int i = 0; i < 2; i++) begin
        cut_q[i] <= CUT_RESET;
        res_q[i] <= RES_RESET;
        mix_q[i] <= MIX_RESET;
      end
      for (int i = 0; i < CHANNELS; i++) begin
        height_q[i] <= '0;
        vel_q[i]    <= '0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CUT_CH0: cut_q[0] <= cfg_wdata_i;
          REG_CUT_CH1: cut_q[1] <= cfg_wdata_i;
          REG_RES_CH0: res_q[0] <= cfg_wdata_i;
          REG_RES_CH1: res_q[1] <= cfg_wdata_i;
          REG_MIX_CH0: mix_q[0] <= cfg_wdata_i;
          REG_MIX_CH1: mix_q[1] <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (commit) begin
        height_q[ch_q] <= h_clip;
        vel_q[ch_q]    <= vel_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cb_q     <= cb_d;
    ch_q     <= ch_d;
    mc_q     <= mc_d;
    mp_q     <= mp_d;
    acc_q    <= acc_d;
    lpin_q   <= lpin_d;
    fm2_q    <= fm2_d;
    result_q <= result_d;
  end

  // an accepted transaction starts the first product at once
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_MUL_MIX) && (cnt_q == '0) && !in_ready_o)
    else $error("accepted transaction did not start the multiplier");

  // the bit counter never runs past the operand width
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL_MIX || state_q == S_MUL_RES || state_q == S_MUL_CUT)
      |-> (cnt_q <= CNT_W'(MP_W - 1)))
    else $error("multiplier bit counter out of range");

  // stored height stays within the clip range after an update
  a_height_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (height_q[ch_q] <= HT_CLIP) && (height_q[ch_q] >= -HT_CLIP))
    else $error("stored height outside clip range");

  // a finished result reaches the output register when it is free
  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) && out_free |=> out_valid_q && (out_q == $past(result_q)))
    else $error("finished result not presented");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Streams samples on both channels of the resonant low-pass filter under random
// handshake gaps and coefficient settings, and checks every filtered sample
// against a bit-true model of the mass-spring update, or a fixed value where a directed row gives one.
// ----------------------------------------------------------------------------
module testbench
  import rlpf_pkg::*;
();

  localparam int FRAC_BITS  = 8;
  localparam int CLIP_LIMIT = 2048;
  localparam longint FIX_ONE = longint'(1) << FRAC_BITS;

  localparam int PHASES       = 11;
  localparam int PHASE_ITEMS  = 48;
  localparam int HOLD_AT      = 90;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 200000;

  // indices past the register map, writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 chan;
    logic [SAMPLE_W-1:0]  value;
    logic                 has_want;
    logic [SAMPLE_W-1:0]  want;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 33;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // centred input from rest stays centred, low nibble is dropped
    '{ROW_SAMPLE, '0, 1'b0, 16'h8000, 1'b1, 16'h8000},
    '{ROW_SAMPLE, '0, 1'b1, 16'h800F, 1'b1, 16'h8000},
    '{ROW_SAMPLE, '0, 1'b0, 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0, 1'b1, 16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0, 1'b0, 16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0, 1'b1, 16'hFFFF, 1'b0, 16'h0000},
    // coefficients near two: velocity runs away and saturates both ways
    '{ROW_WRITE, REG_CUT_CH0, 1'b0, 16'h01FF, 1'b0, 16'h0000},
    '{ROW_WRITE, REG_RES_CH0, 1'b0, 16'h01FF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0, 1'b0, 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0, 1'b0, 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0, 1'b0, 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0, 1'b0, 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0, 1'b0, 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0, 1'b0, 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0, 1'b0, 16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0, 1'b0, 16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0, 1'b0, 16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0, 1'b0, 16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0, 1'b0, 16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0, 1'b0, 16'h0000, 1'b0, 16'h0000},
    // mix above one flips the input sign
    '{ROW_WRITE, REG_MIX_CH1, 1'b0, 16'h01FF, 1'b0, 16'h0000},
    '{ROW_WRITE, REG_CUT_CH1, 1'b0, 16'h0100, 1'b0, 16'h0000},
    '{ROW_WRITE, REG_RES_CH1, 1'b0, 16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0, 1'b1, 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0, 1'b1, 16'h0000, 1'b0, 16'h0000},
    '{ROW_WRITE, REG_SPARE_6, 1'b0, 16'h01FF, 1'b0, 16'h0000},
    '{ROW_WRITE, REG_SPARE_7, 1'b0, 16'h0000, 1'b0, 16'h0000},
    // zero coefficients freeze the channel on its clipped height
    '{ROW_WRITE, REG_CUT_CH0, 1'b0, 16'h0000, 1'b0, 16'h0000},
    '{ROW_WRITE, REG_RES_CH0, 1'b0, 16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0, 1'b0, 16'h8000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0, 1'b1, 16'h7FF0, 1'b0, 16'h0000},
    // mix of exactly one mutes the input
    '{ROW_WRITE, REG_MIX_CH0, 1'b0, 16'h0100, 1'b0, 16'h0000},
    '{ROW_SAMPLE, '0, 1'b0, 16'hFFFF, 1'b0, 16'h0000}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [COEF_W-1:0]    cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 channel_i;
  logic [SAMPLE_W-1:0]  sample_in_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [SAMPLE_W-1:0]  sample_out_o;

  // mirror of the filter: coefficients and per-channel spring state
  logic        [COEF_W-1:0] cut_coef    [2];
  logic        [COEF_W-1:0] res_coef    [2];
  logic        [COEF_W-1:0] mix_coef    [2];
  logic signed [SAMP_W-1:0] lp_height   [2];
  logic signed [VEL_W-1:0]  lp_velocity [2];

  logic [SAMPLE_W-1:0] filtered_q [$];
  int                  error_count;
  int                  results_seen;
  int                  cycle_count;

  resonant_lowpass_filter_unit #(
    .FRAC_BITS (FRAC_BITS),
    .CLIP_LIMIT(CLIP_LIMIT),
    .CHANNELS  (2)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .channel_i   (channel_i),
    .sample_in_i (sample_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_out_o(sample_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint clamp_range(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // one spring update, products floor towards minus infinity
  function automatic logic [SAMPLE_W-1:0] next_filtered_sample(logic ch,
                                                               logic [SAMPLE_W-1:0] raw);
    int     c;
    longint centred;
    longint scaled;
    longint diff;
    longint vel;
    longint h;
    longint out_val;
    c       = int'(ch);
    centred = longint'(raw[SAMPLE_W-1:4]) - longint'(SAMP_CENTRE);
    scaled  = (centred * (FIX_ONE - longint'(mix_coef[c]))) >>> FRAC_BITS;
    diff    = scaled - longint'(lp_height[c]);
    vel     = ((longint'(lp_velocity[c]) * longint'(res_coef[c])) >>> FRAC_BITS)
            + ((diff * longint'(cut_coef[c])) >>> FRAC_BITS);
    vel     = clamp_range(vel, VEL_MIN, VEL_MAX);
    h       = longint'(lp_height[c]) + vel;
    out_val = clamp_range(h * 8 + OUT_OFFSET, 0, OUT_MAX);
    lp_velocity[c] = VEL_W'(vel);
    lp_height[c]   = SAMP_W'(clamp_range(h, -CLIP_LIMIT, CLIP_LIMIT));
    return SAMPLE_W'(out_val);
  endfunction

  task automatic report_error(string what, logic [SAMPLE_W-1:0] want,
                              logic [SAMPLE_W-1:0] got);
    $display("error: %s: sample_out expected %h got %h (cycle %0d)",
             what, want, got, cycle_count);
    error_count++;
  endtask

  task automatic write_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_CUT_CH0: cut_coef[0] = data;
      REG_CUT_CH1: cut_coef[1] = data;
      REG_RES_CH0: res_coef[0] = data;
      REG_RES_CH1: res_coef[1] = data;
      REG_MIX_CH0: mix_coef[0] = data;
      REG_MIX_CH1: mix_coef[1] = data;
      default: ;
    endcase
  endtask

  // offer one transaction and record its expected result once it is taken
  task automatic send_sample(logic ch, logic [SAMPLE_W-1:0] s, int gap,
                             logic has_want, logic [SAMPLE_W-1:0] want);
    logic [SAMPLE_W-1:0] predicted;
    cfg_we_i <= 1'b0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    channel_i   <= ch;
    sample_in_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = next_filtered_sample(ch, s);
    filtered_q.push_back(has_want ? want : predicted);
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (filtered_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [COEF_W-1:0] pick_coef(int lo, int hi);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return COEF_W'(FIX_ONE);
      3:       return COEF_W'($urandom_range(0, 511));
      default: return COEF_W'($urandom_range(lo, hi));
    endcase
  endfunction

  initial begin : stimulus
    stim_row_t           row;
    bit                  streaming;
    bit                  burst;
    logic                ch;
    logic [SAMPLE_W-1:0] s;
    int                  last_sample [2];
    int                  step;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    channel_i   <= 1'b0;
    sample_in_i <= '0;
    error_count = 0;
    streaming   = 1'b0;
    last_sample = '{32768, 32768};
    for (int c = 0; c < 2; c++) begin
      cut_coef[c]    = CUT_RESET;
      res_coef[c]    = RES_RESET;
      mix_coef[c]    = MIX_RESET;
      lp_height[c]   = '0;
      lp_velocity[c] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        if (streaming) begin
          wait_all_results();
          streaming = 1'b0;
        end
        write_coef(row.reg_idx, row.value[COEF_W-1:0]);
      end else begin
        send_sample(row.chan, row.value, $urandom_range(0, 11), row.has_want, row.want);
        streaming = 1'b1;
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      // coefficients only change with the pipe empty
      wait_all_results();
      write_coef(REG_CUT_CH0, pick_coef(8, 160));
      write_coef(REG_CUT_CH1, pick_coef(8, 160));
      write_coef(REG_RES_CH0, pick_coef(192, 256));
      write_coef(REG_RES_CH1, pick_coef(192, 256));
      write_coef(REG_MIX_CH0, pick_coef(0, 128));
      write_coef(REG_MIX_CH1, pick_coef(0, 128));
      if ($urandom_range(0, 2) == 0)
        write_coef($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
                   COEF_W'($urandom_range(0, 511)));
      burst = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        ch = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
          0:       s = '0;
          1:       s = '1;
          2, 3:    s = SAMPLE_W'($urandom());
          default: begin
            // slowly wandering waveform keeps the spring in a sensible range
            step = int'($urandom_range(0, 6000)) - 3000;
            s    = SAMPLE_W'(clamp_range(last_sample[ch] + step, 0, OUT_MAX));
          end
        endcase
        last_sample[ch] = int'(s);
        send_sample(ch, s, burst ? 0 : $urandom_range(0, 11), 1'b0, '0);
      end
    end

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0 && filtered_q.size() == 0) begin
      $display("resonant_lowpass_filter_unit: match");
    end else begin
      $display("resonant_lowpass_filter_unit: mismatch");
    end
    $finish;
  end

  initial begin : result_sink
    int                  stall;
    bit                  fast;
    logic [SAMPLE_W-1:0] want;
    fast         = 1'b0;
    results_seen = 0;
    out_ready_i <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 31) == 0) fast = !fast;
      stall = fast ? 0 : $urandom_range(0, 11);
      // one long back-pressure stretch so the filter stalls its input
      if (results_seen == HOLD_AT) stall = HOLD_CYCLES;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      results_seen++;
      if (filtered_q.size() == 0) begin
        report_error("unexpected transaction", '0, sample_out_o);
      end else begin
        want = filtered_q.pop_front();
        if (sample_out_o !== want) report_error("wrong value", want, sample_out_o);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("resonant_lowpass_filter_unit: mismatch");
    $finish;
  end

endmodule
